// ===== rtl/dvru_pkg.sv =====
// dvru_pkg: types, constants and helper functions of the distance-vector
// route table. Used by dvru_table and distance_vector_route_update.
package dvru_pkg;

    localparam int ROUTER_COUNT = 8;
    localparam int ID_W         = 3;
    localparam int COST_W       = 8;
    localparam int LINKS_W      = 64;
    localparam int ADDR_W       = (ROUTER_COUNT > 1) ? $clog2(ROUTER_COUNT) : 1;

    localparam logic [ID_W:0]   ROUTER_LIMIT = (ID_W + 1)'(ROUTER_COUNT);
    localparam logic [COST_W-1:0] RESET_COST = COST_W'(5);
    localparam logic [COST_W-1:0] RESET_INF  = COST_W'(5);
    localparam logic [LINKS_W-1:0] RESET_LINKS = '1;

    // request codes
    localparam logic FUNC_INIT  = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFINITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_COSTS = 2'd2;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   sender;
        logic [ID_W-1:0]   destination;
        logic [COST_W-1:0] advertised_cost;
    } request_t;

    typedef struct packed {
        logic              changed;
        logic [COST_W-1:0] route_cost;
        logic [ID_W-1:0]   next_hop;
        logic              reachable;
    } result_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [ID_W-1:0]   hop;
        logic              valid;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{cost: RESET_COST, hop: '0, valid: 1'b0};

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return {1'b0, id} < ROUTER_LIMIT;
    endfunction

    function automatic logic [COST_W-1:0] link_to(input logic [LINKS_W-1:0] links,
                                                  input logic [ID_W-1:0] id);
        return links[id * COST_W +: COST_W];
    endfunction

    // entry value written by a table reload
    function automatic entry_t init_entry(input logic [ID_W-1:0]    id,
                                          input logic [ID_W-1:0]    self_id,
                                          input logic [COST_W-1:0]  inf,
                                          input logic [LINKS_W-1:0] links);
        entry_t e;
        logic [COST_W-1:0] lc;
        lc = link_to(links, id);
        if (id == self_id) begin
            e = '{cost: '0, hop: self_id, valid: 1'b1};
        end else if (lc < inf) begin
            e = '{cost: lc, hop: id, valid: 1'b1};
        end else begin
            e = '{cost: inf, hop: '0, valid: 1'b0};
        end
        return e;
    endfunction

    function automatic result_t make_result(input logic              changed,
                                            input entry_t            e,
                                            input logic [COST_W-1:0] inf,
                                            input logic              dest_ok);
        result_t r;
        logic    reach;
        reach = e.valid && (e.cost < inf);
        if (dest_ok) begin
            r.changed    = changed;
            r.route_cost = e.cost;
            r.next_hop   = reach ? e.hop : '0;
            r.reachable  = reach;
        end else begin
            r.changed    = 1'b0;
            r.route_cost = inf;
            r.next_hop   = '0;
            r.reachable  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/distance_vector_route_update.sv =====
// distance_vector_route_update: one router's distance-vector route table.
// Depends on dvru_pkg and dvru_table.
//
// usage
// - request channel: a request is taken at a rising edge with start high and
//   busy low; func init reloads the whole table from the link costs, func
//   route applies one neighbor's advertised cost to one destination
// - result channel: each request yields one result, shown on result for one
//   cycle with done high; the receiver cannot stall it, so the block never
//   waits on the result side
// - config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high; index 0 self id, 1 infinity cost, 2 link costs
// - route request: table read on the accept edge, compare and write-back in
//   the next cycle, with done and result registered at its end; route
//   requests may follow every cycle while busy is low, a write-back to the
//   entry just read is forwarded from the table's last-write register
// - init request: one table write per cycle with busy high until every
//   entry is written, done and result registered with the last write; the
//   single write port of the table memory sets this rate
// - reset: config registers to self id 0, infinity 5, no links; every entry
//   reads as cost 5, hop 0, invalid until it is written
module distance_vector_route_update (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  dvru_pkg::request_t                    request,
    output logic                                  done,
    output dvru_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dvru_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dvru_pkg::LINKS_W-1:0]          cfg_data
);
    import dvru_pkg::*;

    localparam addr_t LAST_ADDR = ADDR_W'(ROUTER_COUNT - 1);

    // control and config state
    state_t              state_reg, state_next;
    addr_t               cnt_reg, cnt_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;
    request_t            req_reg;
    logic [ID_W-1:0]     self_id_reg;
    logic [COST_W-1:0]   inf_reg;
    logic [LINKS_W-1:0]  links_reg;

    // table port signals
    logic                accept;
    logic                wr_en;
    addr_t               wr_addr;
    entry_t              wr_entry;
    entry_t              old_entry;

    // route evaluation
    logic                dest_ok;
    logic                apply;
    logic [COST_W-1:0]   link_cost;
    logic [COST_W:0]     sum_raw;
    logic [COST_W-1:0]   sum_capped;
    logic                old_reach;
    logic                improve;
    entry_t              new_entry;
    entry_t              sweep_entry;
    entry_t              dest_init_entry;

    assign busy      = (state_reg == ST_SWEEP);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    dvru_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (request.destination[ADDR_W-1:0]),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry),
        .rd_entry (old_entry)
    );

    // relaxation of the entry read on the accept edge
    always_comb
    begin
        dest_ok    = id_in_range(req_reg.destination);
        link_cost  = link_to(links_reg, req_reg.sender);
        apply      = (req_reg.func == FUNC_ROUTE) && id_in_range(req_reg.sender)
                     && dest_ok && (req_reg.sender != self_id_reg)
                     && (req_reg.destination != self_id_reg) && (link_cost < inf_reg);
        sum_raw    = {1'b0, link_cost} + {1'b0, req_reg.advertised_cost};
        sum_capped = (sum_raw > {1'b0, inf_reg}) ? inf_reg : sum_raw[COST_W-1:0];
        old_reach  = old_entry.valid && (old_entry.cost < inf_reg);
        improve    = apply && (sum_capped < inf_reg)
                     && (!old_reach || (sum_capped < old_entry.cost));
        new_entry  = improve ? entry_t'{cost: sum_capped, hop: req_reg.sender, valid: 1'b1}
                             : old_entry;
        sweep_entry     = init_entry(ID_W'(cnt_reg), self_id_reg, inf_reg, links_reg);
        dest_init_entry = init_entry(req_reg.destination, self_id_reg, inf_reg, links_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE, ST_EVAL:
            begin
                if (accept)
                begin
                    state_next = (request.func == FUNC_ROUTE) ? ST_EVAL : ST_SWEEP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = req_reg.destination[ADDR_W-1:0];
        wr_entry    = new_entry;
        cnt_next    = '0;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EVAL:
            begin
                wr_en       = improve;
                done_next   = 1'b1;
                result_next = make_result(improve, new_entry, inf_reg, dest_ok);
            end
            ST_SWEEP:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_entry = sweep_entry;
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next    = '0;
                    done_next   = 1'b1;
                    result_next = make_result(1'b0, dest_init_entry, inf_reg, dest_ok);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
            self_id_reg <= '0;
            inf_reg     <= RESET_INF;
            links_reg   <= RESET_LINKS;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SELF_ID:    self_id_reg <= cfg_data[ID_W-1:0];
                    CFG_INFINITY:   inf_reg     <= cfg_data[COST_W-1:0];
                    CFG_LINK_COSTS: links_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

endmodule

// ===== rtl/dvru_table.sv =====
// dvru_table: route entry memory with registered read, per-entry
// written flags and forwarding of the last write. Depends on dvru_pkg.
module dvru_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  dvru_pkg::addr_t rd_addr,
    input  logic            wr_en,
    input  dvru_pkg::addr_t wr_addr,
    input  dvru_pkg::entry_t wr_entry,
    output dvru_pkg::entry_t rd_entry
);
    import dvru_pkg::*;

    entry_t                  mem [ROUTER_COUNT];
    entry_t                  rd_data_reg;
    addr_t                   rd_addr_reg;
    logic [ROUTER_COUNT-1:0] written_reg;
    logic                    fwd_valid_reg;
    addr_t                   fwd_addr_reg;
    entry_t                  fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= wr_en;
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // a write on the same edge as the read is not seen by the memory read
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_entry = fwd_data_reg;
        end
        else if (written_reg[rd_addr_reg])
        begin
            rd_entry = rd_data_reg;
        end
        else
        begin
            rd_entry = RESET_ENTRY;
        end
    end

endmodule
